// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file rna_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RNA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed (same cycle)");

// next-cycle implication
`define RNA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed (next cycle)");

`endif

// File: rtl/core/rna_pkg.sv
`default_nettype none
package rna_pkg;

    localparam int WORD_W = 32;
    localparam int DEN_W  = 31;
    localparam int CNT_W  = $clog2(WORD_W);

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_NEG = 3'd4;

    typedef struct packed {
        logic [2:0]               operation;
        logic signed [WORD_W-1:0] a_numer;
        logic [DEN_W-1:0]         a_denom;
        logic signed [WORD_W-1:0] b_numer;
        logic [DEN_W-1:0]         b_denom;
    } t_in;

    typedef struct packed {
        logic signed [WORD_W-1:0] result_numer;
        logic [DEN_W-1:0]         result_denom;
        logic                     a_less;
        logic                     a_equal;
        logic                     error;
    } t_out;

endpackage
`default_nettype wire

// File: rtl/core/rna_mul.sv
`default_nettype none
module rna_mul import rna_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic signed [WORD_W:0]     i_a,
    input  wire logic signed [WORD_W:0]     i_b,
    output logic signed [2*WORD_W+1:0]      o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end

endmodule
`default_nettype wire

// File: rtl/core/rna_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module rna_div import rna_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [WORD_W-1:0] i_num,
    input  wire logic [WORD_W-1:0] i_den,
    output logic                   o_done,
    output logic [WORD_W-1:0]      o_quo
);

    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_q;
    logic [WORD_W-1:0] r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [WORD_W:0]   rem_sh;
    logic [WORD_W:0]   diff;

    assign rem_sh = {r_rem, r_q[WORD_W-1]};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_q    <= i_num;
                r_den  <= i_den;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!diff[WORD_W]) begin
                    r_rem <= diff[WORD_W-1:0];
                    r_q   <= {r_q[WORD_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[WORD_W-1:0];
                    r_q   <= {r_q[WORD_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule
`default_nettype wire

// File: rtl/core/rna_gcd.sv
`default_nettype none
// Binary gcd: one shift or one subtract per cycle.
module rna_gcd import rna_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [WORD_W-1:0] i_x,
    input  wire logic [WORD_W-1:0] i_y,
    output logic                   o_done,
    output logic [WORD_W-1:0]      o_g
);

    logic [WORD_W-1:0] r_x;
    logic [WORD_W-1:0] r_y;
    logic [WORD_W-1:0] r_g;
    logic [CNT_W-1:0]  r_k;
    logic              r_busy;
    logic              r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_x;
                r_y    <= i_y;
                r_k    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_x == '0 || r_y == '0) begin
                    r_g    <= (r_x | r_y) << r_k;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else if (!r_x[0] && !r_y[0]) begin
                    r_x <= r_x >> 1;
                    r_y <= r_y >> 1;
                    r_k <= r_k + 1'b1;
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (r_x >= r_y) begin
                    r_x <= r_x - r_y;
                end else begin
                    r_y <= r_y - r_x;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_g    = r_g;

endmodule
`default_nettype wire

// File: rtl/core/rational_number_alu_top.sv
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_ready    i_data (t_in)
// result    out        o_valid / i_ready    o_data (t_out)
//
// One item at a time; o_ready is high only while the sequencer is idle.
// Add/subtract: binary gcd of the denominators, two bit-serial divides, then multiplies.
// Multiply/divide: multiplies, then a gcd of the result and two divides to reduce it;
// negate and pass-through skip the gcd and the divider.
// A finished result sits in the output register; the next item is taken while it waits.
// Reset is synchronous, active low, and empties the block.
`default_nettype none
module rational_number_alu_top import rna_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_in  i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out      o_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_CMP_A, S_CMP_B, S_CMP_C, S_MUL_D, S_MUL_E, S_NORM,
        S_NGCD, S_NDIVN, S_NDIVD, S_AGCD, S_ADIVA, S_ADIVB,
        S_AMUL_A, S_AMUL_B, S_AMUL_C, S_AMUL_D, S_FIN
    } t_state;

    t_state                    r_state;
    logic [2:0]                r_op;
    logic signed [WORD_W-1:0]  r_an;
    logic signed [WORD_W-1:0]  r_bn;
    logic [DEN_W-1:0]          r_ad;
    logic [DEN_W-1:0]          r_bd;
    logic signed [2*WORD_W-1:0] r_lhs;
    logic [WORD_W-1:0]         r_nm;
    logic [WORD_W-1:0]         r_dm;
    logic [WORD_W-1:0]         r_g;
    logic [WORD_W-1:0]         r_qa;
    logic [WORD_W-1:0]         r_ta;
    logic [WORD_W-1:0]         r_rn;
    logic [WORD_W-1:0]         r_rd;
    logic                      r_neg;
    logic                      r_less;
    logic                      r_eq;
    logic                      r_err;
    logic                      r_ovalid;
    t_out                      r_out;

    logic signed [WORD_W:0]     mul_a;
    logic signed [WORD_W:0]     mul_b;
    logic signed [2*WORD_W+1:0] mul_p;
    logic                       gcd_start;
    logic [WORD_W-1:0]          gcd_x;
    logic [WORD_W-1:0]          gcd_y;
    logic                       gcd_done;
    logic [WORD_W-1:0]          gcd_g;
    logic                       div_start;
    logic [WORD_W-1:0]          div_num;
    logic [WORD_W-1:0]          div_den;
    logic                       div_done;
    logic [WORD_W-1:0]          div_quo;
    logic [WORD_W-1:0]          abs_nm;
    logic [WORD_W-1:0]          abs_dm;
    logic                       fin_err;

    assign abs_nm  = r_nm[WORD_W-1] ? (~r_nm + 1'b1) : r_nm;
    assign abs_dm  = r_dm[WORD_W-1] ? (~r_dm + 1'b1) : r_dm;
    assign fin_err = r_err || (r_rd[DEN_W-1:0] == '0);

    always_comb begin
        mul_a = {r_an[WORD_W-1], r_an};
        mul_b = {2'b00, r_bd};
        case (r_state)
            S_CMP_B: begin
                mul_a = {2'b00, r_ad};
                mul_b = {r_bn[WORD_W-1], r_bn};
            end
            S_CMP_C: begin
                mul_b = {r_bn[WORD_W-1], r_bn};
            end
            S_MUL_D: begin
                mul_a = {2'b00, r_ad};
                mul_b = {2'b00, r_bd};
            end
            S_AMUL_A: begin
                mul_b = {1'b0, div_quo};
            end
            S_AMUL_B: begin
                mul_a = {r_bn[WORD_W-1], r_bn};
                mul_b = {1'b0, r_qa};
            end
            S_AMUL_C: begin
                mul_a = {1'b0, r_qa};
                mul_b = {2'b00, r_bd};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        gcd_start = 1'b0;
        gcd_x     = abs_nm;
        gcd_y     = abs_dm;
        if (r_state == S_NORM && r_dm != '0) begin
            gcd_start = 1'b1;
        end else if (r_state == S_CMP_C && (r_op == OP_ADD || r_op == OP_SUB)
                     && r_ad != '0 && r_bd != '0) begin
            gcd_start = 1'b1;
            gcd_x     = {1'b0, r_ad};
            gcd_y     = {1'b0, r_bd};
        end
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = r_nm;
        div_den   = gcd_g;
        case (r_state)
            S_NGCD: begin
                div_start = gcd_done;
            end
            S_NDIVN: begin
                div_start = div_done;
                div_num   = r_dm;
                div_den   = r_g;
            end
            S_AGCD: begin
                div_start = gcd_done;
                div_num   = {1'b0, r_ad};
            end
            S_ADIVA: begin
                div_start = div_done;
                div_num   = {1'b0, r_bd};
                div_den   = r_g;
            end
            default: begin
            end
        endcase
    end

    rna_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    rna_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (gcd_start),
        .i_x     (gcd_x),
        .i_y     (gcd_y),
        .o_done  (gcd_done),
        .o_g     (gcd_g)
    );

    rna_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_err    <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op    <= i_data.operation;
                        r_an    <= i_data.a_numer;
                        r_ad    <= i_data.a_denom;
                        r_bn    <= i_data.b_numer;
                        r_bd    <= i_data.b_denom;
                        r_eq    <= (i_data.a_numer == i_data.b_numer)
                                   && (i_data.a_denom == i_data.b_denom);
                        r_err   <= 1'b0;
                        r_state <= S_CMP_A;
                    end
                end
                S_CMP_A: begin
                    r_state <= S_CMP_B;
                end
                S_CMP_B: begin
                    r_lhs   <= mul_p[2*WORD_W-1:0];
                    r_state <= S_CMP_C;
                end
                S_CMP_C: begin
                    r_less <= r_lhs < $signed(mul_p[2*WORD_W-1:0]);
                    case (r_op)
                        OP_ADD, OP_SUB: begin
                            if (r_ad == '0 || r_bd == '0) begin
                                r_err   <= 1'b1;
                                r_state <= S_FIN;
                            end else begin
                                r_state <= S_AGCD;
                            end
                        end
                        OP_MUL: begin
                            r_state <= S_MUL_D;
                        end
                        OP_DIV: begin
                            r_nm    <= r_lhs[WORD_W-1:0];
                            r_dm    <= mul_p[WORD_W-1:0];
                            r_state <= S_NORM;
                        end
                        OP_NEG: begin
                            r_rn    <= -r_an;
                            r_rd    <= {1'b0, r_ad};
                            r_state <= S_FIN;
                        end
                        default: begin
                            r_rn    <= r_an;
                            r_rd    <= {1'b0, r_ad};
                            r_state <= S_FIN;
                        end
                    endcase
                end
                S_MUL_D: begin
                    r_nm    <= mul_p[WORD_W-1:0];
                    r_state <= S_MUL_E;
                end
                S_MUL_E: begin
                    r_dm    <= mul_p[WORD_W-1:0];
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    r_neg <= r_nm[WORD_W-1] ^ r_dm[WORD_W-1];
                    r_nm  <= abs_nm;
                    r_dm  <= abs_dm;
                    if (r_dm == '0) begin
                        r_err   <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_NGCD;
                    end
                end
                S_NGCD: begin
                    if (gcd_done) begin
                        r_g     <= gcd_g;
                        r_state <= S_NDIVN;
                    end
                end
                S_NDIVN: begin
                    if (div_done) begin
                        r_nm    <= div_quo;
                        r_state <= S_NDIVD;
                    end
                end
                S_NDIVD: begin
                    if (div_done) begin
                        r_rn    <= r_neg ? (~r_nm + 1'b1) : r_nm;
                        r_rd    <= div_quo;
                        r_state <= S_FIN;
                    end
                end
                S_AGCD: begin
                    if (gcd_done) begin
                        r_g     <= gcd_g;
                        r_state <= S_ADIVA;
                    end
                end
                S_ADIVA: begin
                    if (div_done) begin
                        r_qa    <= div_quo;
                        r_state <= S_ADIVB;
                    end
                end
                S_ADIVB: begin
                    if (div_done) begin
                        r_state <= S_AMUL_A;
                    end
                end
                // divider holds bd/g in its quotient register here
                S_AMUL_A: begin
                    r_state <= S_AMUL_B;
                end
                S_AMUL_B: begin
                    r_ta    <= mul_p[WORD_W-1:0];
                    r_state <= S_AMUL_C;
                end
                S_AMUL_C: begin
                    r_rn    <= (r_op == OP_ADD) ? (r_ta + mul_p[WORD_W-1:0])
                                                : (r_ta - mul_p[WORD_W-1:0]);
                    r_state <= S_AMUL_D;
                end
                S_AMUL_D: begin
                    r_rd    <= mul_p[WORD_W-1:0];
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_ovalid || i_ready) begin
                        r_out.result_numer <= fin_err ? '0 : r_rn;
                        r_out.result_denom <= fin_err ? '0 : r_rd[DEN_W-1:0];
                        r_out.a_less       <= r_less;
                        r_out.a_equal      <= r_eq;
                        r_out.error        <= fin_err;
                        r_ovalid           <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

endmodule
`default_nettype wire

// File: rtl/core/rna_checker.sv
`default_nettype none
`include "assert_macros.svh"
module rna_checker import rna_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_ready,
    input wire t_in  i_data,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire t_out o_data
);

    logic in_acc;
    logic err_zero;

    assign in_acc   = i_valid && o_ready;
    assign err_zero = (o_data.result_numer == '0) && (o_data.result_denom == '0);

    `RNA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data))
    `RNA_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_valid && o_data.error, err_zero)
    `RNA_ASSERT_IMP(a_ok_denom, i_clk, i_rst_n, o_valid && !o_data.error, o_data.result_denom != '0)
    `RNA_ASSERT_NXT(a_busy, i_clk, i_rst_n, in_acc, !o_ready)

endmodule

bind rational_number_alu_top rna_checker u_rna_checker (.*);
`default_nettype wire
